[hw/rtl/hsc_pkg.sv]
// Package for the HMAC-SHA-1 short code signer/verifier.
// Holds payload structs, status and command codes, controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps
package hsc_pkg;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  period;
    logic [7:0]  counter;
    logic [31:0] code;
  } in_item_t;

  typedef struct packed {
    logic [25:0] code_out;
    logic [4:0]  res_period;
    logic [7:0]  res_counter;
    logic [1:0]  status;
  } out_item_t;

  localparam logic       CMD_GEN = 1'b0;
  localparam logic       CMD_VER = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_PER  = 2'd1;
  localparam logic [1:0] ST_BAD_CODE = 2'd2;
  localparam logic [1:0] ST_BAD_SIG  = 2'd3;

  localparam logic [2:0] CFG_IAB  = 3'd0;
  localparam logic [2:0] CFG_ICD  = 3'd1;
  localparam logic [2:0] CFG_IE   = 3'd2;
  localparam logic [2:0] CFG_OAB  = 3'd3;
  localparam logic [2:0] CFG_OCD  = 3'd4;
  localparam logic [2:0] CFG_OE   = 3'd5;
  localparam logic [2:0] CFG_MASK = 3'd6;

  typedef struct packed {
    logic load_item;
    logic load_inner;
    logic load_outer;
    logic round;
    logic finish;
    logic check;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic early_done;
  } sts_t;

endpackage

[hw/rtl/hsc_ctrl.sv]
// Controller for the short code block: sequences two 80-round compressions,
// or skips them when the item fails its checks. Depends on hsc_pkg.
`timescale 1ns / 1ps
module hsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic [6:0]    round_idx,
  output hsc_pkg::ctl_t ctl,
  input  hsc_pkg::sts_t sts
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_IRND  = 3'd2;
  localparam logic [2:0] S_IFIN  = 3'd3;
  localparam logic [2:0] S_ORND  = 3'd4;
  localparam logic [2:0] S_OFIN  = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  assign busy      = (state_r != S_IDLE);
  assign round_idx = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load_item = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (sts.early_done) begin
          state_nxt = S_OUT;
        end else begin
          ctl.load_inner = 1'b1;
          state_nxt = S_IRND;
        end
      end
      S_IRND: begin
        ctl.round = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd79) state_nxt = S_IFIN;
      end
      S_IFIN: begin
        ctl.load_outer = 1'b1;
        state_nxt = S_ORND;
        cnt_nxt = '0;
      end
      S_ORND: begin
        ctl.round = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd79) state_nxt = S_OFIN;
      end
      S_OFIN: begin
        ctl.finish = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        ctl.check = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ctl.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule

[hw/rtl/hsc_dp.sv]
// Datapath: one SHA-1 round per cycle with a 16-word schedule window,
// config registers, item checks and result packing. Depends on hsc_pkg.
`timescale 1ns / 1ps
module hsc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  hsc_pkg::in_item_t in_item,
  input  logic [6:0]        round_idx,
  input  hsc_pkg::ctl_t     ctl,
  output hsc_pkg::sts_t     sts,
  output logic              out_valid,
  output hsc_pkg::out_item_t out_item
);
  logic [63:0] iab_r, icd_r, oab_r, ocd_r;
  logic [31:0] ie_r, oe_r, mask_r;
  logic        cmd_r, early_r;
  logic [4:0]  per_r;
  logic [7:0]  ctr_r;
  logic [12:0] sig_r;
  logic [1:0]  st_r;
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic        vld_r;
  hsc_pkg::out_item_t res_r, res_nxt;

  logic [31:0] c_code;
  logic        c_bad_code, c_bad_per;
  logic [4:0]  c_per;
  logic [7:0]  c_ctr;
  logic [31:0] f, k, tmp, wt, wn;
  logic [31:0] sum4;

  always_comb begin
    c_code     = in_item.code;
    c_bad_code = (in_item.cmd == hsc_pkg::CMD_VER) && (c_code[31:26] != 6'd0);
    c_per      = (in_item.cmd == hsc_pkg::CMD_VER) ? c_code[25:21] : in_item.period;
    c_ctr      = (in_item.cmd == hsc_pkg::CMD_VER) ? c_code[20:13] : in_item.counter;
    c_bad_per  = !mask_r[c_per];
  end

  assign sts.early_done = early_r;

  always_comb begin
    if (round_idx < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = 32'h5A827999;
    end else if (round_idx < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = 32'h6ED9EBA1;
    end else if (round_idx < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r; k = 32'hCA62C1D6;
    end
    wt   = w_r[0];
    tmp  = {a_r[26:0], a_r[31:27]} + f + e_r + k + wt;
    sum4 = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wn   = {sum4[30:0], sum4[31]};
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.status = st_r;
    if (st_r == hsc_pkg::ST_OK) begin
      if (cmd_r == hsc_pkg::CMD_GEN) res_nxt.code_out = {per_r, ctr_r, h_r[4][12:0]};
      else begin
        res_nxt.res_period  = per_r;
        res_nxt.res_counter = ctr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iab_r <= '0; icd_r <= '0; ie_r <= '0;
      oab_r <= '0; ocd_r <= '0; oe_r <= '0; mask_r <= '0;
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.emit;
      if (cfg_we) begin
        unique case (cfg_index)
          hsc_pkg::CFG_IAB:  iab_r  <= cfg_data;
          hsc_pkg::CFG_ICD:  icd_r  <= cfg_data;
          hsc_pkg::CFG_IE:   ie_r   <= cfg_data[31:0];
          hsc_pkg::CFG_OAB:  oab_r  <= cfg_data;
          hsc_pkg::CFG_OCD:  ocd_r  <= cfg_data;
          hsc_pkg::CFG_OE:   oe_r   <= cfg_data[31:0];
          hsc_pkg::CFG_MASK: mask_r <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r   <= in_item.cmd;
      per_r   <= c_per;
      ctr_r   <= c_ctr;
      sig_r   <= c_code[12:0];
      early_r <= c_bad_code || c_bad_per;
      st_r    <= c_bad_code ? hsc_pkg::ST_BAD_CODE :
                 (c_bad_per ? hsc_pkg::ST_BAD_PER : hsc_pkg::ST_OK);
    end
    if (ctl.load_inner) begin
      h_r[0] <= iab_r[63:32]; h_r[1] <= iab_r[31:0];
      h_r[2] <= icd_r[63:32]; h_r[3] <= icd_r[31:0]; h_r[4] <= ie_r;
      a_r <= iab_r[63:32]; b_r <= iab_r[31:0];
      c_r <= icd_r[63:32]; d_r <= icd_r[31:0]; e_r <= ie_r;
      w_r[0]  <= {3'b000, per_r, ctr_r, 16'h8000};
      for (int i = 1; i < 15; i++) w_r[i] <= '0;
      w_r[15] <= 32'd528;
    end
    if (ctl.round) begin
      e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r; a_r <= tmp;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
    end
    if (ctl.finish) begin
      h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
    end
    if (ctl.load_outer) begin
      w_r[0] <= h_r[0] + a_r; w_r[1] <= h_r[1] + b_r; w_r[2] <= h_r[2] + c_r;
      w_r[3] <= h_r[3] + d_r; w_r[4] <= h_r[4] + e_r;
      w_r[5]  <= 32'h80000000;
      for (int i = 6; i < 15; i++) w_r[i] <= '0;
      w_r[15] <= 32'd672;
      h_r[0] <= oab_r[63:32]; h_r[1] <= oab_r[31:0];
      h_r[2] <= ocd_r[63:32]; h_r[3] <= ocd_r[31:0]; h_r[4] <= oe_r;
      a_r <= oab_r[63:32]; b_r <= oab_r[31:0];
      c_r <= ocd_r[63:32]; d_r <= ocd_r[31:0]; e_r <= oe_r;
    end
    if (ctl.check) begin
      if (cmd_r == hsc_pkg::CMD_VER && h_r[4][12:0] != sig_r) st_r <= hsc_pkg::ST_BAD_SIG;
    end
    if (ctl.emit) res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_item  = res_r;
endmodule

[hw/rtl/hmac_sha1_short_code_sign_verify.sv]
// Top level of the HMAC-SHA-1 short code signer/verifier.
// From the accepting edge an item passes the check, then two 80-round compressions at one
// round per cycle with the finish steps, then the compare and output steps; an item that
// fails its period or range check goes from the check straight to the output step.
// One item at a time; the next start is taken at the result edge at the earliest.
// Receiver cannot stall. Synchronous active-low reset clears control and key registers.
`timescale 1ns / 1ps
module hmac_sha1_short_code_sign_verify (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hsc_pkg::in_item_t  in_item,
  output logic               out_valid,
  output hsc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  hsc_pkg::ctl_t ctl;
  hsc_pkg::sts_t sts;
  logic [6:0]    round_idx;
  logic          busy_i;

  assign cfg_ready = 1'b1;
  assign busy = busy_i;

  hsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy_i),
    .round_idx(round_idx), .ctl(ctl), .sts(sts)
  );

  hsc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_item), .round_idx(round_idx), .ctl(ctl),
    .sts(sts), .out_valid(out_valid), .out_item(out_item)
  );

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> busy_i) else $error("emit while idle");
  a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ctl.emit)) else $error("result without emit");
endmodule
